/* rtl/core/tksd_pkg.sv */
// Package for the terminal key sequence decoder: decoder modes, digit-parse
// status codes, the fixed byte and key-code constants and the number limits.
// No dependencies.
package tksd_pkg;

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_ESC  = 3'd1,
        M_CSI  = 3'd2,
        M_SS2  = 3'd3,
        M_SS3  = 3'd4,
        M_UTF8 = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        PS_NONE   = 2'd0,
        PS_DIGITS = 2'd1,
        PS_ENDED  = 2'd2,
        PS_FAILED = 2'd3
    } t_pstat;

    typedef struct packed {
        logic [30:0] num;
        t_pstat      st;
        logic        ovf;
    } t_feed;

    localparam logic [7:0]  BYTE_ESC   = 8'h1B;
    localparam logic [7:0]  BYTE_CSI   = 8'h5B;
    localparam logic [7:0]  BYTE_SS2   = 8'h4E;
    localparam logic [7:0]  BYTE_SS3   = 8'h4F;
    localparam logic [7:0]  BYTE_SEMI  = 8'h3B;
    localparam logic [7:0]  BYTE_REPORT = 8'h52;

    localparam logic [31:0] CODE_CSI      = 32'h4000_0000;
    localparam logic [31:0] CODE_OVERFLOW = 32'hF000_0000;
    localparam logic [31:0] CODE_BAD_CONT = 32'hFFFF_FFFE;
    localparam logic [31:0] CODE_BAD_LEAD = 32'hFFFF_FFFF;
    localparam logic [23:0] CODE_OTHER_HI = 24'hC0_0001;
    localparam logic [23:0] CODE_SS_HI    = 24'h80_0000;
    localparam logic [3:0]  CODE_SIZE_HI  = 4'hD;

    localparam logic [4:0]  SHIFT_MAX   = 5'd24;
    localparam logic [30:0] NUM_LIMIT   = 31'h7FFF_FFFF;
    // (NUM_LIMIT - d) / 10 for digit values below eight and for eight or nine
    localparam logic [30:0] NUM_GUARD_LO = 31'd214748364;
    localparam logic [30:0] NUM_GUARD_HI = 31'd214748363;

endpackage

/* rtl/core/terminal_key_sequence_decoder_unit.sv */
// Terminal key sequence decoder: turns terminal bytes and empty events into
// 32-bit key codes (Unicode, CSI, SS2/SS3, escape, cursor report).
// Depends on tksd_pkg.
// A key code is registered into the output register in the cycle after the
// transaction that completes it. Throughput: one input transaction per cycle;
// the next decoder state is computed combinationally for each byte, and a held
// result stalls input only while it is not taken. Synchronous active-low reset
// returns the decoder to idle with the decoder state cleared and no result pending.
module terminal_key_sequence_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_byte_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_key_code
);
    import tksd_pkg::*;

    t_mode       r_mode, n_mode;
    logic [31:0] r_acc, n_acc;
    logic [4:0]  r_shift, n_shift;
    logic [1:0]  r_rem, n_rem;
    logic        r_bad, n_bad;
    logic [30:0] r_row, n_row;
    t_pstat      r_row_st, n_row_st;
    logic [30:0] r_col, n_col;
    t_pstat      r_col_st, n_col_st;
    logic        r_sep, n_sep;
    logic        r_too_large, n_too_large;
    logic        r_out_valid;
    logic [31:0] r_out_code;

    logic        in_fire;
    logic        emit;
    logic [31:0] res;
    logic        is_param, is_final;
    logic [5:0]  pval;
    t_feed       rf, cf;
    logic        ovf;
    t_pstat      cs;
    logic [30:0] cv;

    function automatic t_feed f_feed(logic [30:0] num, t_pstat st, logic [7:0] b);
        t_feed       r;
        logic        dig;
        logic [3:0]  d;
        logic [30:0] guard;
        r.num = num;
        r.st  = st;
        r.ovf = 1'b0;
        dig   = (b >= 8'h30) && (b <= 8'h39);
        d     = b[3:0];
        guard = (d >= 4'd8) ? NUM_GUARD_HI : NUM_GUARD_LO;
        unique case (st)
            PS_NONE: begin
                if (dig) begin
                    r.num = {27'd0, d};
                    r.st  = PS_DIGITS;
                end else begin
                    r.st = PS_FAILED;
                end
            end
            PS_DIGITS: begin
                if (!dig) begin
                    r.st = PS_ENDED;
                end else if (num > guard) begin
                    r.ovf = 1'b1;
                    r.num = NUM_LIMIT;
                end else begin
                    r.num = {num[27:0], 3'b000} + {num[29:0], 1'b0} + {27'd0, d};
                end
            end
            PS_ENDED, PS_FAILED: begin
            end
        endcase
        return r;
    endfunction

    assign o_ready    = !r_out_valid || i_ready;
    assign in_fire    = i_valid && o_ready;
    assign o_valid    = r_out_valid;
    assign o_key_code = r_out_code;

    assign is_param = (i_byte_in >= 8'h20) && (i_byte_in <= 8'h3F);
    assign is_final = (i_byte_in >= 8'h40) && (i_byte_in <= 8'h7E);
    assign pval     = is_param ? {1'b0, i_byte_in[4:0]} : i_byte_in[5:0];

    // Next mode
    always_comb begin
        n_mode = r_mode;
        if (in_fire) begin
            if (i_action) begin
                n_mode = M_IDLE;
            end else begin
                unique case (r_mode)
                    M_ESC: begin
                        if (i_byte_in == BYTE_CSI)      n_mode = M_CSI;
                        else if (i_byte_in == BYTE_SS2) n_mode = M_SS2;
                        else if (i_byte_in == BYTE_SS3) n_mode = M_SS3;
                        else                            n_mode = M_IDLE;
                    end
                    M_SS2, M_SS3: n_mode = M_IDLE;
                    M_UTF8: begin
                        if (r_rem == 2'd1) n_mode = M_IDLE;
                    end
                    M_CSI: begin
                        if (is_final) n_mode = M_IDLE;
                    end
                    default: begin
                        if (i_byte_in == BYTE_ESC) begin
                            n_mode = M_ESC;
                        end else if (i_byte_in[7:5] == 3'b110 || i_byte_in[7:4] == 4'b1110
                                     || i_byte_in[7:3] == 5'b11110) begin
                            n_mode = M_UTF8;
                        end else begin
                            n_mode = M_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    // Datapath and result
    always_comb begin
        n_acc       = r_acc;
        n_shift     = r_shift;
        n_rem       = r_rem;
        n_bad       = r_bad;
        n_row       = r_row;
        n_row_st    = r_row_st;
        n_col       = r_col;
        n_col_st    = r_col_st;
        n_sep       = r_sep;
        n_too_large = r_too_large;
        emit        = 1'b0;
        res         = 32'd0;
        rf          = f_feed(r_row, r_row_st, i_byte_in);
        cf          = f_feed(r_col, r_col_st, i_byte_in);
        ovf         = r_too_large;
        cs          = r_row_st;
        cv          = r_row;
        if (in_fire) begin
            if (i_action) begin
                emit = 1'b1;
                if (r_mode == M_CSI)       res = r_acc;
                else if (r_mode == M_UTF8) res = CODE_BAD_LEAD;
                else                       res = 32'd0;
            end else begin
                unique case (r_mode)
                    M_ESC: begin
                        if (i_byte_in == BYTE_CSI) begin
                            n_acc       = CODE_CSI;
                            n_shift     = 5'd0;
                            n_row       = 31'd0;
                            n_row_st    = PS_NONE;
                            n_col       = 31'd0;
                            n_col_st    = PS_NONE;
                            n_sep       = 1'b0;
                            n_too_large = 1'b0;
                        end else if (i_byte_in != BYTE_SS2 && i_byte_in != BYTE_SS3) begin
                            emit = 1'b1;
                            res  = {CODE_OTHER_HI, i_byte_in};
                        end
                    end
                    M_SS2: begin
                        emit = 1'b1;
                        res  = {CODE_SS_HI, i_byte_in};
                    end
                    M_SS3: begin
                        emit = 1'b1;
                        res  = {CODE_SS_HI, 1'b1, i_byte_in[6:0]};
                    end
                    M_UTF8: begin
                        if (i_byte_in[7:6] == 2'b10) n_acc = {r_acc[25:0], i_byte_in[5:0]};
                        else                         n_bad = 1'b1;
                        n_rem = r_rem - 2'd1;
                        if (n_rem == 2'd0) begin
                            emit = 1'b1;
                            res  = n_bad ? CODE_BAD_CONT : n_acc;
                        end
                    end
                    M_CSI: begin
                        n_row    = rf.num;
                        n_row_st = rf.st;
                        ovf      = r_too_large || rf.ovf;
                        if (r_sep) begin
                            n_col    = cf.num;
                            n_col_st = cf.st;
                            ovf      = ovf || cf.ovf;
                        end else if (i_byte_in == BYTE_SEMI) begin
                            n_sep    = 1'b1;
                            n_col    = 31'd0;
                            n_col_st = PS_NONE;
                        end
                        n_too_large = ovf;
                        if (is_param || is_final) begin
                            if (r_shift <= SHIFT_MAX) begin
                                n_acc   = r_acc | ({26'd0, pval} << r_shift);
                                n_shift = r_shift + (is_param ? 5'd5 : 5'd6);
                            end else begin
                                n_acc = CODE_OVERFLOW;
                            end
                        end
                        if (is_final) begin
                            emit = 1'b1;
                            res  = n_acc;
                            cs   = n_sep ? n_col_st : n_row_st;
                            cv   = n_sep ? n_col : n_row;
                            // cursor report: digits present, no number overflowed
                            if (i_byte_in == BYTE_REPORT
                                && (n_row_st == PS_DIGITS || n_row_st == PS_ENDED)
                                && (cs == PS_DIGITS || cs == PS_ENDED) && !ovf) begin
                                res = {CODE_SIZE_HI, n_row[11:0], cv[15:0]};
                            end
                        end
                    end
                    default: begin
                        if (i_byte_in == BYTE_ESC) begin
                            emit = 1'b0;
                        end else if (!i_byte_in[7]) begin
                            emit = 1'b1;
                            res  = {24'd0, i_byte_in};
                        end else if (i_byte_in[7:5] == 3'b110) begin
                            n_acc = {27'd0, i_byte_in[4:0]};
                            n_rem = 2'd1;
                            n_bad = 1'b0;
                        end else if (i_byte_in[7:4] == 4'b1110) begin
                            n_acc = {28'd0, i_byte_in[3:0]};
                            n_rem = 2'd2;
                            n_bad = 1'b0;
                        end else if (i_byte_in[7:3] == 5'b11110) begin
                            n_acc = {29'd0, i_byte_in[2:0]};
                            n_rem = 2'd3;
                            n_bad = 1'b0;
                        end else begin
                            emit = 1'b1;
                            res  = CODE_BAD_LEAD;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_acc       <= 32'd0;
            r_shift     <= 5'd0;
            r_rem       <= 2'd0;
            r_bad       <= 1'b0;
            r_row       <= 31'd0;
            r_row_st    <= PS_NONE;
            r_col       <= 31'd0;
            r_col_st    <= PS_NONE;
            r_sep       <= 1'b0;
            r_too_large <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_acc       <= n_acc;
            r_shift     <= n_shift;
            r_rem       <= n_rem;
            r_bad       <= n_bad;
            r_row       <= n_row;
            r_row_st    <= n_row_st;
            r_col       <= n_col;
            r_col_st    <= n_col_st;
            r_sep       <= n_sep;
            r_too_large <= n_too_large;
            // hold the result until its transaction completes
            if (emit)         r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_out_code <= res;
    end

endmodule

/* tb/tksd_key_checker.sv */
// Scoreboard for the terminal key sequence decoder: predicts the key codes that
// accepted input transactions produce and checks the accepted results in order.
// Depends on tksd_pkg; also holds tksd_tb_pkg, shared with the testbench top.
`timescale 1ns / 100ps

package tksd_tb_pkg;
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_EMPTY = 1'b1;
endpackage

module tksd_key_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_req_action,
    input  logic [7:0]  i_req_byte,
    input  logic        i_key_valid,
    input  logic        i_key_ready,
    input  logic [31:0] i_key_code,
    output int          o_mismatches,
    output int          o_keys_outstanding
);
    import tksd_pkg::*;
    import tksd_tb_pkg::*;

    localparam logic [31:0] KEY_SS      = 32'h8000_0000;
    localparam logic [31:0] KEY_SS3_BIT = 32'h0000_0080;
    localparam logic [31:0] KEY_OTHER   = 32'hC000_0100;
    localparam logic [3:0]  KEY_SIZE_HI = 4'hD;
    localparam logic [31:0] NUMBER_MAX  = 32'h7FFF_FFFF;

    // decoder copy
    t_mode       key_mode   = M_IDLE;
    logic [31:0] acc        = '0;
    logic [4:0]  pack_pos   = '0;
    logic [1:0]  utf8_left  = '0;
    logic        utf8_bad   = 1'b0;
    logic [31:0] row_num    = '0;
    t_pstat      row_state  = PS_NONE;
    logic [31:0] col_num    = '0;
    t_pstat      col_state  = PS_NONE;
    logic        semi_seen  = 1'b0;
    logic        num_big    = 1'b0;

    logic [31:0] expected_keys[$];
    int          mismatch_count = 0;
    int          keys_waiting   = 0;

    assign o_mismatches       = mismatch_count;
    assign o_keys_outstanding = keys_waiting;

    function automatic void feed_number(inout logic [31:0] num, inout t_pstat st,
                                        inout logic big, input logic [7:0] b);
        logic        is_digit;
        logic [31:0] d;
        is_digit = (b >= 8'h30) && (b <= 8'h39);
        d = {24'd0, b} - 32'h30;
        case (st)
            PS_NONE: begin
                if (is_digit) begin
                    num = d;
                    st  = PS_DIGITS;
                end else begin
                    st = PS_FAILED;
                end
            end
            PS_DIGITS: begin
                if (!is_digit) begin
                    st = PS_ENDED;
                end else if (num > (NUMBER_MAX - d) / 10) begin
                    // saturate and flag the report as unusable
                    big = 1'b1;
                    num = NUMBER_MAX;
                end else begin
                    num = num * 10 + d;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic has_digits(input t_pstat st);
        return (st == PS_DIGITS) || (st == PS_ENDED);
    endfunction

    // Advance the decoder copy by one transaction; returns 1 when a key is due.
    function automatic logic predict_key(input logic act, input logic [7:0] b,
                                         output logic [31:0] key);
        logic [31:0] report_col;
        t_pstat      report_state;
        key = '0;
        if (act == ACT_EMPTY) begin
            case (key_mode)
                M_CSI:   key = acc;
                M_UTF8:  key = CODE_BAD_LEAD;
                default: key = '0;
            endcase
            key_mode = M_IDLE;
            return 1'b1;
        end
        case (key_mode)
            M_ESC: begin
                if (b == BYTE_CSI) begin
                    key_mode  = M_CSI;
                    acc       = CODE_CSI;
                    pack_pos  = '0;
                    row_num   = '0;
                    row_state = PS_NONE;
                    col_num   = '0;
                    col_state = PS_NONE;
                    semi_seen = 1'b0;
                    num_big   = 1'b0;
                    return 1'b0;
                end
                if (b == BYTE_SS2) begin
                    key_mode = M_SS2;
                    return 1'b0;
                end
                if (b == BYTE_SS3) begin
                    key_mode = M_SS3;
                    return 1'b0;
                end
                key = KEY_OTHER | {24'd0, b};
            end
            M_SS2: key = KEY_SS | {24'd0, b};
            M_SS3: key = KEY_SS | KEY_SS3_BIT | {24'd0, b};
            M_UTF8: begin
                if (b[7:6] == 2'b10) acc = {acc[25:0], b[5:0]};
                else utf8_bad = 1'b1;
                utf8_left = utf8_left - 2'd1;
                if (utf8_left != 2'd0) return 1'b0;
                key = utf8_bad ? CODE_BAD_CONT : acc;
            end
            M_CSI: begin
                feed_number(row_num, row_state, num_big, b);
                if (semi_seen) begin
                    feed_number(col_num, col_state, num_big, b);
                end else if (b == BYTE_SEMI) begin
                    semi_seen = 1'b1;
                    col_num   = '0;
                    col_state = PS_NONE;
                end
                if (b >= 8'h20 && b <= 8'h3F) begin
                    if (pack_pos <= 5'd24) begin
                        acc      = acc | (({24'd0, b} - 32'h20) << pack_pos);
                        pack_pos = pack_pos + 5'd5;
                    end else begin
                        acc = CODE_OVERFLOW;
                    end
                    return 1'b0;
                end
                if (b < 8'h40 || b > 8'h7E) return 1'b0;
                if (pack_pos <= 5'd24) begin
                    acc      = acc | (({24'd0, b} - 32'h40) << pack_pos);
                    pack_pos = pack_pos + 5'd6;
                end else begin
                    acc = CODE_OVERFLOW;
                end
                key = acc;
                if (b == BYTE_REPORT) begin
                    report_col   = semi_seen ? col_num : row_num;
                    report_state = semi_seen ? col_state : row_state;
                    if (has_digits(row_state) && has_digits(report_state) && !num_big)
                        key = {KEY_SIZE_HI, row_num[11:0], report_col[15:0]};
                end
            end
            default: begin
                if (b == BYTE_ESC) begin
                    key_mode = M_ESC;
                    return 1'b0;
                end
                if (b <= 8'h7F) begin
                    key = {24'd0, b};
                end else begin
                    if (b[7:5] == 3'b110) begin
                        acc       = {27'd0, b[4:0]};
                        utf8_left = 2'd1;
                    end else if (b[7:4] == 4'b1110) begin
                        acc       = {28'd0, b[3:0]};
                        utf8_left = 2'd2;
                    end else if (b[7:3] == 5'b11110) begin
                        acc       = {29'd0, b[2:0]};
                        utf8_left = 2'd3;
                    end else begin
                        key      = CODE_BAD_LEAD;
                        key_mode = M_IDLE;
                        return 1'b1;
                    end
                    utf8_bad = 1'b0;
                    key_mode = M_UTF8;
                    return 1'b0;
                end
            end
        endcase
        key_mode = M_IDLE;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : track
        logic [31:0] predicted;
        logic [31:0] oldest;
        if (!i_rst_n) begin
            key_mode  = M_IDLE;
            acc       = '0;
            pack_pos  = '0;
            utf8_left = '0;
            utf8_bad  = 1'b0;
            row_num   = '0;
            row_state = PS_NONE;
            col_num   = '0;
            col_state = PS_NONE;
            semi_seen = 1'b0;
            num_big   = 1'b0;
            expected_keys.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                if (predict_key(i_req_action, i_req_byte, predicted))
                    expected_keys.push_back(predicted);
            end
            if (i_key_valid && i_key_ready) begin
                if (expected_keys.size() == 0) begin
                    $error("key_code: expected no result, actual %h", i_key_code);
                    mismatch_count++;
                end else begin
                    oldest = expected_keys.pop_front();
                    if (i_key_code !== oldest) begin
                        $error("key_code: expected %h, actual %h", oldest, i_key_code);
                        mismatch_count++;
                    end
                end
            end
        end
        keys_waiting = expected_keys.size();
    end

endmodule

/* tb/terminal_key_sequence_decoder_unit_tb.sv */
// Testbench top for terminal_key_sequence_decoder_unit: directed and random key
// sequences under several idle and stall mixes, with a watchdog and the verdict.
// Depends on tksd_pkg, tksd_tb_pkg and tksd_key_checker.
`timescale 1ns / 100ps

module terminal_key_sequence_decoder_unit_tb;
    import tksd_pkg::*;
    import tksd_tb_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int ITEMS_PER_PHASE = 190;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic        i_action  = 1'b0;
    logic [7:0]  i_byte_in = 8'h00;
    logic        i_ready   = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_key_code;

    int          mismatches;
    int          keys_outstanding;
    logic        req_taken    = 1'b0;
    int          quiet_cycles = 0;
    int          items_sent   = 0;
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned idle_plan[4]  = '{0, 84, 0, 18};
    int unsigned stall_plan[4] = '{0, 0, 84, 18};

    terminal_key_sequence_decoder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_byte_in  (i_byte_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_key_code (o_key_code)
    );

    tksd_key_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_valid),
        .i_req_ready        (o_ready),
        .i_req_action       (i_action),
        .i_req_byte         (i_byte_in),
        .i_key_valid        (o_valid),
        .i_key_ready        (i_ready),
        .i_key_code         (o_key_code),
        .o_mismatches       (mismatches),
        .o_keys_outstanding (keys_outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        req_taken <= i_valid && o_ready;
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("terminal_key_sequence_decoder_unit_tb: done, errors");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_event(input logic act, input logic [7:0] b);
        logic [7:0] payload;
        payload = (act == ACT_EMPTY) ? 8'($urandom_range(255)) : b;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_byte_in <= payload;
        do @(negedge i_clk); while (!req_taken);
        items_sent++;
    endtask

    // Hold off the sender until every expected key has come out.
    task automatic drain_keys();
        i_valid <= 1'b0;
        while (keys_outstanding != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic send_utf8();
        int unsigned tail;
        int unsigned r;
        logic [7:0]  lead;
        bit          cut;
        tail = $urandom_range(1, 3);
        cut  = 1'b0;
        case (tail)
            1:       lead = 8'hC0 | 8'($urandom_range(31));
            2:       lead = 8'hE0 | 8'($urandom_range(15));
            default: lead = 8'hF0 | 8'($urandom_range(7));
        endcase
        send_event(ACT_BYTE, lead);
        for (int i = 0; i < tail && !cut; i++) begin
            r = $urandom_range(99);
            if (r < 6) begin
                send_event(ACT_EMPTY, 8'h00);
                cut = 1'b1;
            end else if (r < 14) begin
                send_event(ACT_BYTE, 8'($urandom_range(255)));
            end else begin
                send_event(ACT_BYTE, 8'h80 | 8'($urandom_range(63)));
            end
        end
    endtask

    task automatic send_escape();
        int unsigned pick;
        pick = $urandom_range(4);
        send_event(ACT_BYTE, BYTE_ESC);
        case (pick)
            0, 1: begin
                send_event(ACT_BYTE, (pick == 0) ? BYTE_SS2 : BYTE_SS3);
                if ($urandom_range(9) == 0) send_event(ACT_EMPTY, 8'h00);
                else send_event(ACT_BYTE, 8'($urandom_range(255)));
            end
            2:       send_event(ACT_EMPTY, 8'h00);
            default: send_event(ACT_BYTE, 8'($urandom_range(255)));
        endcase
    endtask

    task automatic send_csi();
        int unsigned body_len;
        int unsigned r;
        body_len = $urandom_range(8);
        send_event(ACT_BYTE, BYTE_ESC);
        send_event(ACT_BYTE, BYTE_CSI);
        repeat (body_len) begin
            r = $urandom_range(99);
            if (r < 55) send_event(ACT_BYTE, 8'($urandom_range(8'h20, 8'h3F)));
            else if (r < 75) send_event(ACT_BYTE, 8'h30 + 8'($urandom_range(9)));
            else if (r < 85) send_event(ACT_BYTE, BYTE_SEMI);
            else if (r < 93) send_event(ACT_BYTE, 8'($urandom_range(8'h1F)));
            else send_event(ACT_BYTE, 8'($urandom_range(8'h7F, 8'hFF)));
        end
        r = $urandom_range(99);
        if (r < 10) send_event(ACT_EMPTY, 8'h00);
        else if (r < 25) send_event(ACT_BYTE, BYTE_REPORT);
        else send_event(ACT_BYTE, 8'($urandom_range(8'h40, 8'h7E)));
    endtask

    // One decimal run of a cursor report: empty, short, around the limit or very long.
    task automatic send_number();
        int unsigned r;
        int unsigned value;
        logic [7:0]  digit_bytes[$];
        r = $urandom_range(99);
        if (r >= 88) begin
            repeat ($urandom_range(11, 13))
                send_event(ACT_BYTE, 8'h30 + 8'($urandom_range(9)));
        end else if (r >= 8) begin
            if (r < 70) value = $urandom_range(9999);
            else value = 32'd2147483640 + $urandom_range(15);
            if ($urandom_range(7) == 0) send_event(ACT_BYTE, 8'h30);
            do begin
                digit_bytes.push_front(8'h30 + 8'(value % 10));
                value = value / 10;
            end while (value != 0);
            foreach (digit_bytes[i]) send_event(ACT_BYTE, digit_bytes[i]);
        end
    endtask

    task automatic send_report();
        send_event(ACT_BYTE, BYTE_ESC);
        send_event(ACT_BYTE, BYTE_CSI);
        send_number();
        if ($urandom_range(3) != 0) begin
            send_event(ACT_BYTE, BYTE_SEMI);
            send_number();
        end
        if ($urandom_range(9) == 0) send_event(ACT_BYTE, 8'($urandom_range(8'h20, 8'h3F)));
        send_event(ACT_BYTE, BYTE_REPORT);
    endtask

    task automatic send_random_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) send_event(ACT_BYTE, 8'($urandom_range(8'h7F)));
        else if (r < 35) send_utf8();
        else if (r < 50) send_escape();
        else if (r < 80) send_csi();
        else if (r < 92) send_report();
        else send_event(1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // plain byte extremes, empty in idle, bad leads
        send_event(ACT_BYTE, 8'h00);
        send_event(ACT_BYTE, 8'h7F);
        send_event(ACT_EMPTY, 8'h00);
        send_event(ACT_BYTE, 8'h80);
        send_event(ACT_BYTE, 8'hFF);
        // two-byte character, bad continuation, missing continuation
        send_event(ACT_BYTE, 8'hC3);
        send_event(ACT_BYTE, 8'hA9);
        send_event(ACT_BYTE, 8'hC3);
        send_event(ACT_BYTE, 8'h41);
        send_event(ACT_BYTE, 8'hE2);
        send_event(ACT_EMPTY, 8'h00);
        // escape then empty, SS3, escape with another byte
        send_event(ACT_BYTE, BYTE_ESC);
        send_event(ACT_EMPTY, 8'h00);
        send_event(ACT_BYTE, BYTE_ESC);
        send_event(ACT_BYTE, BYTE_SS3);
        send_event(ACT_BYTE, 8'hFF);
        send_event(ACT_BYTE, BYTE_ESC);
        send_event(ACT_BYTE, 8'h71);
        // cursor report 3;40
        send_event(ACT_BYTE, BYTE_ESC);
        send_event(ACT_BYTE, BYTE_CSI);
        send_event(ACT_BYTE, 8'h33);
        send_event(ACT_BYTE, BYTE_SEMI);
        send_event(ACT_BYTE, 8'h34);
        send_event(ACT_BYTE, 8'h30);
        send_event(ACT_BYTE, BYTE_REPORT);
        drain_keys();

        for (int p = 0; p < 4; p++) begin
            sender_idle_pct    = idle_plan[p];
            receiver_stall_pct = stall_plan[p];
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE) send_random_key();
            drain_keys();
        end

        repeat (4) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("terminal_key_sequence_decoder_unit_tb: done, clean");
        end else begin
            $display("terminal_key_sequence_decoder_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
